// ===== sv/pacc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacc_pkg
// Shared types, fixed-point constants and rounding helper for the boost PFC
// average-current-mode controller.
// ----------------------------------------------------------------------------
package pacc_pkg;

    // Shared multiplier and divider widths
    localparam int MUL_W  = 34;
    localparam int PROD_W = 68;
    localparam int DIV_W  = 48;
    localparam int DVS_W  = 21;

    typedef logic signed [MUL_W-1:0]  opnd_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // Scaling and filter coefficients (Q16 gains, Q30 filter taps)
    localparam opnd_t GAIN_V = opnd_t'(140834);
    localparam opnd_t GAIN_I = opnd_t'(126547);
    localparam opnd_t LPF_A  = opnd_t'(1070854350);
    localparam opnd_t LPF_B  = opnd_t'(1443739);

    // Clamp bounds in internal Q16 formats
    localparam prod_t VDC_LIM   = prod_t'(576716800);   // 8800 * 2^16
    localparam prod_t AMP_MAX   = prod_t'(369098752);   // 22 A * 256 * 2^16
    localparam prod_t ERR_MAX   = prod_t'(64'sd2147483647);
    localparam prod_t ERR_MIN   = prod_t'(-64'sd2147483648);

    // Configuration register indexes
    localparam logic [2:0] REG_VDC_REF   = 3'd0;
    localparam logic [2:0] REG_AC_CREST  = 3'd1;
    localparam logic [2:0] REG_VGAINS    = 3'd2;
    localparam logic [2:0] REG_IGAINS    = 3'd3;
    localparam logic [2:0] REG_LIMIT     = 3'd4;
    localparam logic [2:0] REG_PERIOD    = 3'd5;
    localparam logic [2:0] REG_OFFSETS   = 3'd6;

    // Divider request
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    // Arithmetic shift right by n, rounding half away from zero
    function automatic prod_t rnd_shift(input prod_t x, input int n);
        prod_t h;
        h = prod_t'(1) <<< (n - 1);
        if (x < 0)
            return (x + h - prod_t'(1)) >>> n;
        else
            return (x + h) >>> n;
    endfunction

endpackage

// ===== sv/pfc_average_current_control_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_average_current_control_unit
// Boost PFC average-current-mode controller: ADC scaling, bus low-pass,
// incremental PI voltage and current loops, feed-forward and compare clamp.
// ----------------------------------------------------------------------------
// Channel   Signals                      Content
// s_axis    tvalid tready tdata tuser    one ADC sample triple per PWM period
// m_axis    tvalid tready tdata          compare, amplitude, filtered bus
// cfg       cfg_we cfg_addr cfg_wdata    register writes, no read-back
//
// Each item makes two passes of the 48-step shared divider (current reference
// and feed-forward); the second pass is skipped when vdc_ref is zero, and the
// voltage-loop steps are skipped when the voltage loop is not run.
// s_axis_tready is high only while the sequencer is idle. A finished result
// sits in the output register; the next item is taken meanwhile and stalls
// only at its own output step. Reset restores loop state and config registers.
// ----------------------------------------------------------------------------
module pfc_average_current_control_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // vac_sample, iac_sample, vdc_sample
    input  logic [0:0]  s_axis_tuser,   // run_voltage_loop
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // pwm_compare, current_amplitude, vdc_filtered
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [39:0] cfg_wdata
);

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001, S_VAC  = 20'h00002, S_IAC  = 20'h00004,
        S_VDC  = 20'h00008, S_LPFA = 20'h00010, S_LPFB = 20'h00020,
        S_LPFS = 20'h00040, S_VKP  = 20'h00080, S_VKI  = 20'h00100,
        S_VUPD = 20'h00200, S_REF  = 20'h00400, S_D1S  = 20'h00800,
        S_D1W  = 20'h01000, S_IKP  = 20'h02000, S_IKI  = 20'h04000,
        S_IUPD = 20'h08000, S_FFM  = 20'h10000, S_D2S  = 20'h20000,
        S_D2W  = 20'h40000, S_OUT  = 20'h80000
    } state_t;

    // Configuration registers
    logic [12:0] vdc_ref_reg;
    logic [12:0] ac_crest_reg;
    logic [39:0] vgains_reg;
    logic [39:0] igains_reg;
    logic [11:0] limit_reg;
    logic [15:0] period_reg;
    logic [35:0] offsets_reg;

    // Sequencer and loop state
    state_t             state_reg, state_next;
    logic [35:0]        in_reg, in_next;
    logic               run_reg, run_next;
    logic signed [14:0] vac_reg, vac_next;
    logic signed [14:0] iac_reg, iac_next;
    logic signed [14:0] vdc_reg, vdc_next;
    logic signed [14:0] prev_vdc_reg, prev_vdc_next;
    logic signed [30:0] lpf_reg, lpf_next;
    logic signed [29:0] amp_reg, amp_next;
    logic signed [31:0] pve_reg, pve_next;
    logic signed [31:0] pce_reg, pce_next;
    logic signed [29:0] clo_reg, clo_next;
    logic signed [31:0] ei_reg, ei_next;
    pacc_pkg::prod_t    tmp_reg, tmp_next;
    logic               sign_reg, sign_next;
    logic               out_valid_reg, out_valid_next;
    logic [15:0]        pwm_reg, pwm_next;
    logic [12:0]        amp_out_reg, amp_out_next;
    logic [14:0]        vdcf_reg, vdcf_next;

    // Shared units
    logic                       mul_en;
    pacc_pkg::opnd_t            mul_a, mul_b;
    pacc_pkg::prod_t            mul_p;
    pacc_pkg::div_req_t         div_req;
    logic                       div_done;
    logic [pacc_pkg::DIV_W-1:0] div_quo;

    // Derived operands
    logic signed [12:0] vac_raw, iac_raw, vdc_raw;
    logic signed [31:0] e_val;
    logic [12:0]        peak_eff;

    pacc_mul u_mul
    (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    pacc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Offset removal and voltage error
    always_comb
    begin
        vac_raw  = $signed({1'b0, in_reg[11:0]})  - $signed({1'b0, offsets_reg[11:0]});
        iac_raw  = $signed({1'b0, in_reg[23:12]}) - $signed({1'b0, offsets_reg[23:12]});
        vdc_raw  = $signed({1'b0, in_reg[35:24]}) - $signed({1'b0, offsets_reg[35:24]});
        e_val    = $signed({3'b0, vdc_ref_reg, 16'b0}) - 32'(lpf_reg);
        peak_eff = (ac_crest_reg == 13'd0) ? 13'd1 : ac_crest_reg;
    end

    // Sequencer: issue at most one multiply or divide per step, fold in the last result
    always_comb
    begin
        pacc_pkg::prod_t acc;
        pacc_pkg::prod_t r;
        pacc_pkg::prod_t mag;
        pacc_pkg::prod_t q;
        pacc_pkg::prod_t lim;

        state_next     = state_reg;
        in_next        = in_reg;
        run_next       = run_reg;
        vac_next       = vac_reg;
        iac_next       = iac_reg;
        vdc_next       = vdc_reg;
        prev_vdc_next  = prev_vdc_reg;
        lpf_next       = lpf_reg;
        amp_next       = amp_reg;
        pve_next       = pve_reg;
        pce_next       = pce_reg;
        clo_next       = clo_reg;
        ei_next        = ei_reg;
        tmp_next       = tmp_reg;
        sign_next      = sign_reg;
        out_valid_next = out_valid_reg;
        pwm_next       = pwm_reg;
        amp_out_next   = amp_out_reg;
        vdcf_next      = vdcf_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_req        = '0;
        acc            = '0;
        r              = '0;
        mag            = (mul_p < 0) ? -mul_p : mul_p;
        q              = pacc_pkg::prod_t'({20'b0, div_quo});
        lim            = pacc_pkg::prod_t'({1'b0, limit_reg, 16'b0});

        // Drop the held result once transferred
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_next    = s_axis_tdata[35:0];
                    run_next   = s_axis_tuser[0];
                    state_next = S_VAC;
                end
            end
            S_VAC:
            begin
                mul_en     = 1'b1;
                mul_a      = pacc_pkg::opnd_t'(vac_raw);
                mul_b      = pacc_pkg::GAIN_V;
                state_next = S_IAC;
            end
            S_IAC:
            begin
                r          = pacc_pkg::rnd_shift(mul_p, 16);
                vac_next   = r[14:0];
                mul_en     = 1'b1;
                mul_a      = pacc_pkg::opnd_t'(iac_raw);
                mul_b      = pacc_pkg::GAIN_I;
                state_next = S_VDC;
            end
            S_VDC:
            begin
                r          = pacc_pkg::rnd_shift(mul_p, 16);
                iac_next   = r[14:0];
                mul_en     = 1'b1;
                mul_a      = pacc_pkg::opnd_t'(vdc_raw);
                mul_b      = pacc_pkg::GAIN_V;
                state_next = S_LPFA;
            end
            S_LPFA:
            begin
                r          = pacc_pkg::rnd_shift(mul_p, 16);
                vdc_next   = r[14:0];
                mul_en     = 1'b1;
                mul_a      = pacc_pkg::LPF_A;
                mul_b      = pacc_pkg::opnd_t'(lpf_reg);
                state_next = S_LPFB;
            end
            S_LPFB:
            begin
                tmp_next   = mul_p;
                mul_en     = 1'b1;
                mul_a      = pacc_pkg::LPF_B;
                mul_b      = pacc_pkg::opnd_t'(vdc_reg) + pacc_pkg::opnd_t'(prev_vdc_reg);
                state_next = S_LPFS;
            end
            S_LPFS:
            begin
                acc = tmp_reg + (mul_p <<< 16);
                r   = pacc_pkg::rnd_shift(acc, 30);
                if (r > pacc_pkg::VDC_LIM)
                    r = pacc_pkg::VDC_LIM;
                else if (r < -pacc_pkg::VDC_LIM)
                    r = -pacc_pkg::VDC_LIM;
                lpf_next      = r[30:0];
                prev_vdc_next = vdc_reg;
                state_next    = run_reg ? S_VKP : S_REF;
            end
            S_VKP:
            begin
                mul_en     = 1'b1;
                mul_a      = pacc_pkg::opnd_t'({1'b0, vgains_reg[39:24]});
                mul_b      = pacc_pkg::opnd_t'(e_val) - pacc_pkg::opnd_t'(pve_reg);
                state_next = S_VKI;
            end
            S_VKI:
            begin
                tmp_next   = pacc_pkg::rnd_shift(mul_p, 4);
                mul_en     = 1'b1;
                mul_a      = pacc_pkg::opnd_t'({1'b0, vgains_reg[23:0]});
                mul_b      = pacc_pkg::opnd_t'(e_val);
                state_next = S_VUPD;
            end
            S_VUPD:
            begin
                acc = pacc_pkg::prod_t'(amp_reg) + tmp_reg + pacc_pkg::rnd_shift(mul_p, 16);
                if (acc > pacc_pkg::AMP_MAX)
                    acc = pacc_pkg::AMP_MAX;
                else if (acc < 0)
                    acc = '0;
                amp_next   = acc[29:0];
                pve_next   = e_val;
                state_next = S_REF;
            end
            S_REF:
            begin
                mul_en     = 1'b1;
                mul_a      = pacc_pkg::opnd_t'(amp_reg);
                mul_b      = pacc_pkg::opnd_t'(vac_reg);
                state_next = S_D1S;
            end
            S_D1S:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mag[pacc_pkg::DIV_W-1:0]
                                 + pacc_pkg::DIV_W'({peak_eff, 7'b0});
                div_req.divisor  = {peak_eff, 8'b0};
                sign_next        = (mul_p < 0);
                state_next       = S_D1W;
            end
            S_D1W:
            begin
                if (div_done)
                begin
                    acc = (sign_reg ? -q : q) - (pacc_pkg::prod_t'(iac_reg) <<< 8);
                    if (acc > pacc_pkg::ERR_MAX)
                        acc = pacc_pkg::ERR_MAX;
                    else if (acc < pacc_pkg::ERR_MIN)
                        acc = pacc_pkg::ERR_MIN;
                    ei_next    = acc[31:0];
                    state_next = S_IKP;
                end
            end
            S_IKP:
            begin
                mul_en     = 1'b1;
                mul_a      = pacc_pkg::opnd_t'({1'b0, igains_reg[39:24]});
                mul_b      = pacc_pkg::opnd_t'(ei_reg) - pacc_pkg::opnd_t'(pce_reg);
                state_next = S_IKI;
            end
            S_IKI:
            begin
                tmp_next   = pacc_pkg::rnd_shift(mul_p, 8);
                mul_en     = 1'b1;
                mul_a      = pacc_pkg::opnd_t'({1'b0, igains_reg[23:0]});
                mul_b      = pacc_pkg::opnd_t'(ei_reg);
                state_next = S_IUPD;
            end
            S_IUPD:
            begin
                acc = pacc_pkg::prod_t'(clo_reg) + tmp_reg + pacc_pkg::rnd_shift(mul_p, 24);
                if (acc > lim)
                    acc = lim;
                else if (acc < -lim)
                    acc = -lim;
                clo_next   = acc[29:0];
                pce_next   = ei_reg;
                state_next = S_FFM;
            end
            S_FFM:
            begin
                mul_en     = 1'b1;
                mul_a      = pacc_pkg::opnd_t'({1'b0, period_reg});
                mul_b      = pacc_pkg::opnd_t'(vac_reg);
                state_next = S_D2S;
            end
            S_D2S:
            begin
                // Feed-forward is zero with no bus target
                if (vdc_ref_reg == 13'd0)
                begin
                    tmp_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    acc              = mag <<< 16;
                    div_req.start    = 1'b1;
                    div_req.dividend = acc[pacc_pkg::DIV_W-1:0]
                                     + pacc_pkg::DIV_W'(vdc_ref_reg[12:1]);
                    div_req.divisor  = pacc_pkg::DVS_W'(vdc_ref_reg);
                    sign_next        = (mul_p < 0);
                    state_next       = S_D2W;
                end
            end
            S_D2W:
            begin
                if (div_done)
                begin
                    tmp_next   = pacc_pkg::prod_t'({36'b0, period_reg, 16'b0})
                               - (sign_reg ? -q : q);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    r = pacc_pkg::rnd_shift(pacc_pkg::prod_t'(clo_reg) + tmp_reg, 16);
                    if (r > pacc_pkg::prod_t'({52'b0, period_reg}))
                        r = pacc_pkg::prod_t'({52'b0, period_reg});
                    else if (r < 0)
                        r = '0;
                    pwm_next       = r[15:0];
                    acc            = pacc_pkg::rnd_shift(pacc_pkg::prod_t'(amp_reg), 16);
                    amp_out_next   = acc[12:0];
                    acc            = pacc_pkg::rnd_shift(pacc_pkg::prod_t'(lpf_reg), 16);
                    vdcf_next      = acc[14:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vdc_ref_reg  <= 13'd0;
            ac_crest_reg <= 13'd5200;
            vgains_reg   <= 40'd0;
            igains_reg   <= 40'd0;
            limit_reg    <= 12'd50;
            period_reg   <= 16'd692;
            offsets_reg  <= 36'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                pacc_pkg::REG_VDC_REF:  vdc_ref_reg  <= cfg_wdata[12:0];
                pacc_pkg::REG_AC_CREST: ac_crest_reg <= cfg_wdata[12:0];
                pacc_pkg::REG_VGAINS:   vgains_reg   <= cfg_wdata;
                pacc_pkg::REG_IGAINS:   igains_reg   <= cfg_wdata;
                pacc_pkg::REG_LIMIT:    limit_reg    <= cfg_wdata[11:0];
                pacc_pkg::REG_PERIOD:   period_reg   <= cfg_wdata[15:0];
                pacc_pkg::REG_OFFSETS:  offsets_reg  <= cfg_wdata[35:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            prev_vdc_reg  <= '0;
            lpf_reg       <= '0;
            amp_reg       <= '0;
            pve_reg       <= '0;
            pce_reg       <= '0;
            clo_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            prev_vdc_reg  <= prev_vdc_next;
            lpf_reg       <= lpf_next;
            amp_reg       <= amp_next;
            pve_reg       <= pve_next;
            pce_reg       <= pce_next;
            clo_reg       <= clo_next;
        end
    end

    // Working and output payload
    always_ff @(posedge clk)
    begin
        in_reg      <= in_next;
        run_reg     <= run_next;
        vac_reg     <= vac_next;
        iac_reg     <= iac_next;
        vdc_reg     <= vdc_next;
        ei_reg      <= ei_next;
        tmp_reg     <= tmp_next;
        sign_reg    <= sign_next;
        pwm_reg     <= pwm_next;
        amp_out_reg <= amp_out_next;
        vdcf_reg    <= vdcf_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, vdcf_reg, amp_out_reg, pwm_reg};

endmodule

// ===== sv/pacc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacc_mul
// Shared signed multiplier with a registered product, loaded on enable.
// ----------------------------------------------------------------------------
module pacc_mul
(
    input  logic            clk,
    input  logic            en,
    input  pacc_pkg::opnd_t a,
    input  pacc_pkg::opnd_t b,
    output pacc_pkg::prod_t p
);

    pacc_pkg::prod_t p_reg;
    pacc_pkg::prod_t p_next;

    // Multiply full width
    always_comb
    begin
        p_next = pacc_pkg::prod_t'(a) * pacc_pkg::prod_t'(b);
    end

    // Hold product until the next issue
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== sv/pacc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pacc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pacc_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  pacc_pkg::div_req_t         req,
    output logic                       done,
    output logic [pacc_pkg::DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(pacc_pkg::DIV_W);

    logic [pacc_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [pacc_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [pacc_pkg::DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [pacc_pkg::DVS_W:0]   trial;

    // Shift in one dividend bit, subtract when it fits
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[pacc_pkg::DIV_W-1]};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = pacc_pkg::DVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[pacc_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[pacc_pkg::DVS_W-1:0];
                quo_next = {quo_reg[pacc_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(pacc_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
